### src/lrdc_pkg.sv
// Package for the log record deframer/checker: status codes, register indexes,
// header layout constants and the byte-wide CRC-32 update. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lrdc_pkg;
  localparam int unsigned HdrLen = 28;
  localparam int unsigned CrcLen = 4;
  localparam int unsigned MinRecLen = 32;
  localparam logic [47:0] CountMax = 48'hffff_ffff_ffff;
  localparam logic [31:0] CrcPoly = 32'hedb8_8320;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_CORRUPT = 3'd1;
  localparam logic [2:0] ST_SEQUENCE = 3'd2;
  localparam logic [2:0] ST_TRUNC = 3'd3;
  localparam logic [2:0] ST_END = 3'd4;

  localparam logic [2:0] REG_MAGIC = 3'd0;
  localparam logic [2:0] REG_VERSION = 3'd1;
  localparam logic [2:0] REG_SET_OP = 3'd2;
  localparam logic [2:0] REG_DEL_OP = 3'd3;
  localparam logic [2:0] REG_MAX_KEY = 3'd4;
  localparam logic [2:0] REG_MAX_VALUE = 3'd5;
  localparam logic [2:0] REG_MAX_RECORD = 3'd6;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        in_value;
    logic [2:0]  status;
    logic [7:0]  opcode;
    logic [63:0] sequence_res;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic [31:0] record_bytes;
    logic [47:0] good_bytes;
  } out_item_t;

  // Reflected CRC-32, one byte: eight unrolled shift steps
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

### src/lrdc_stream_if.sv
// Valid/ready channel interface carrying one payload beat of type payload_t.
// Depends on nothing; payload types come from lrdc_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none
interface lrdc_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/lrdc_out_skid.sv
// Two-entry output skid buffer: decouples upstream ready from the result sink.
// Depends on lrdc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrdc_out_skid import lrdc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire out_item_t push_data,
  output logic           can_push,
  output logic           out_valid,
  output out_item_t      out_data,
  input  wire logic      out_ready
);
  out_item_t main_q, skid_q;
  logic main_v, skid_v;

  assign can_push = !skid_v;
  assign out_valid = main_v;
  assign out_data = main_q;

  // main holds the presented beat, skid catches one while main stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!main_v || out_ready) begin
        if (skid_v) begin
          main_q <= skid_q;
          main_v <= 1'b1;
          skid_v <= push;
          skid_q <= push_data;
        end else begin
          main_v <= push;
          main_q <= push_data;
        end
      end else if (push) begin
        skid_v <= 1'b1;
        skid_q <= push_data;
      end
    end
  end
endmodule
`default_nettype wire

### src/log_record_deframer_checker.sv
// Top level of the log record deframer/checker.
// Depends on lrdc_pkg, lrdc_stream_if and lrdc_out_skid.
`timescale 1ns / 1ps
`default_nettype none
// One stream byte or end marker per cycle, sustained: header parse, CRC
// byte update and the length/sequence checks all finish in the cycle a beat
// is accepted, and the result goes to a two-entry skid buffer. in.ready drops
// only while the skid buffer holds a second beat. After any verdict other
// than ok the block halts (accepts and discards beats) until reset.
module log_record_deframer_checker import lrdc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  lrdc_stream_if.sink      in,
  lrdc_stream_if.source    out,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [31:0] magic_word, max_key, max_value, max_record;
  logic [15:0] format_version;
  logic [7:0]  set_op, del_op;

  logic [31:0] byte_position, running_crc, crc_trailer;
  logic [7:0]  hdr [HdrLen];
  logic [63:0] last_seq;
  logic [47:0] count;
  logic        header_fault, halted;

  logic      can_push, push, acc;
  out_item_t res;
  in_item_t  item;

  assign item = in.payload;
  assign in.ready = can_push;
  assign acc = in.valid && in.ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word <= '0; format_version <= 16'd1; set_op <= 8'd1; del_op <= 8'd2;
      max_key <= 32'd65535; max_value <= 32'd1048576; max_record <= 32'd2097152;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:      magic_word <= cfg_data;
        REG_VERSION:    format_version <= cfg_data[15:0];
        REG_SET_OP:     set_op <= cfg_data[7:0];
        REG_DEL_OP:     del_op <= cfg_data[7:0];
        REG_MAX_KEY:    max_key <= cfg_data;
        REG_MAX_VALUE:  max_value <= cfg_data;
        REG_MAX_RECORD: max_record <= cfg_data;
        default: ;
      endcase
    end
  end

  // header fields; the 28th byte comes straight from the input
  logic [7:0]  b;
  logic        last_hdr;
  logic [31:0] h_total, h_klen, h_vlen, h_magic, crc_new;
  logic [63:0] h_seq;
  logic [15:0] h_ver;
  logic [7:0]  h_op;
  logic [32:0] expect_len;
  logic        hdr_bad, op_bad, have_hdr;

  assign b = item.data_byte;
  assign last_hdr = byte_position == 32'(HdrLen - 1);
  assign h_magic = {hdr[0], hdr[1], hdr[2], hdr[3]};
  assign h_ver = {hdr[4], hdr[5]};
  assign h_op = hdr[6];
  assign h_total = {hdr[8], hdr[9], hdr[10], hdr[11]};
  assign h_seq = {hdr[12], hdr[13], hdr[14], hdr[15], hdr[16], hdr[17], hdr[18], hdr[19]};
  assign h_klen = {hdr[20], hdr[21], hdr[22], hdr[23]};
  assign h_vlen = last_hdr ? {hdr[24], hdr[25], hdr[26], b} : {hdr[24], hdr[25], hdr[26], hdr[27]};
  assign expect_len = 33'(MinRecLen) + {1'b0, h_klen} + {1'b0, h_vlen};
  assign hdr_bad = h_magic != magic_word || h_ver != format_version || hdr[7] != 8'd0
      || h_klen == 32'd0 || h_klen > max_key || h_vlen > max_value
      || {1'b0, h_total} != expect_len || h_total > max_record;
  assign op_bad = (h_op != set_op && h_op != del_op) || (h_op == del_op && h_vlen != 32'd0);
  assign crc_new = crc_feed(running_crc, b);

  logic [31:0] crc_at, pos_off, stored_next, pos_inc;
  logic        in_hdr, in_body, rec_last, crc_good, seq_good;
  logic [48:0] count_sum;
  assign pos_inc = byte_position + 32'd1;
  assign in_hdr = byte_position < 32'(HdrLen);
  assign crc_at = h_total - 32'(CrcLen);
  assign in_body = byte_position < crc_at;
  assign pos_off = byte_position - 32'(HdrLen);
  assign stored_next = {crc_trailer[23:0], b};
  assign rec_last = !(pos_inc < h_total);
  assign crc_good = stored_next == ~running_crc;
  assign seq_good = last_seq != '1 && h_seq == last_seq + 64'd1;
  assign count_sum = {1'b0, count} + {17'd0, h_total};

  // result formation and state update
  logic verdict;
  logic [2:0] vstat;
  always_comb begin
    push = 1'b0;
    verdict = 1'b0;
    vstat = ST_OK;
    have_hdr = 1'b1;
    res = '0;
    if (acc && !halted) begin
      if (item.mode) begin
        verdict = 1'b1;
        vstat = byte_position == 32'd0 ? ST_END : ST_TRUNC;
        have_hdr = !in_hdr;
      end else if (in_hdr) begin
        if (last_hdr && hdr_bad) begin
          verdict = 1'b1;
          vstat = ST_CORRUPT;
        end
      end else if (in_body) begin
        push = 1'b1;
        res.payload_byte = b;
        res.in_value = pos_off >= h_klen;
      end else if (rec_last) begin
        verdict = 1'b1;
        if (header_fault || !crc_good) vstat = ST_CORRUPT;
        else if (!seq_good) vstat = ST_SEQUENCE;
        else vstat = ST_OK;
      end
    end
    if (verdict) begin
      push = 1'b1;
      res.kind = 1'b1;
      res.status = vstat;
      if (have_hdr) begin
        res.opcode = h_op;
        res.sequence_res = h_seq;
        res.key_length = h_klen;
        res.value_length = h_vlen;
      end
      if (vstat == ST_OK) begin
        res.record_bytes = h_total;
        res.good_bytes = count_sum[48] ? CountMax : count_sum[47:0];
      end else begin
        res.good_bytes = count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !halted && !item.mode && in_hdr) hdr[byte_position[4:0]] <= b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0; running_crc <= '1; crc_trailer <= '0;
      last_seq <= '0; count <= '0; header_fault <= 1'b0; halted <= 1'b0;
    end else if (acc && !halted) begin
      if (verdict && vstat != ST_OK) begin
        halted <= 1'b1;
      end else if (verdict) begin
        last_seq <= h_seq;
        count <= res.good_bytes;
        byte_position <= '0; running_crc <= '1; crc_trailer <= '0;
        header_fault <= 1'b0;
      end else begin
        byte_position <= pos_inc;
        if (in_hdr || in_body) running_crc <= crc_new;
        else crc_trailer <= stored_next;
        if (in_hdr && last_hdr && op_bad) header_fault <= 1'b1;
      end
    end
  end

  lrdc_out_skid u_skid (
    .clk(clk), .rst(rst), .push(push), .push_data(res), .can_push(can_push),
    .out_valid(out.valid), .out_data(out.payload), .out_ready(out.ready)
  );

  // checks
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted) else $error("halt cleared without reset");
  a_verdict_nonok_halts: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind && res.status != ST_OK) |=> halted)
    else $error("bad verdict did not halt");
  a_count_monotone: assert property (@(posedge clk) disable iff (rst)
    count >= $past(count) || $past(rst)) else $error("count went backward");
endmodule
`default_nettype wire
